// File: hdl/utf8sd_pkg.sv
// Types, constants and decode helpers for the UTF-8 stream decoder.
package utf8sd_pkg;

   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned HELD_DEPTH  = 3;
   localparam logic [20:0] SUBST_CHAR  = 21'h00003F;

   typedef struct packed {
      logic [20:0] code_point;
      logic        run_end;
      logic        string_end;
   } rsp_entry_type;

   // Sequence length set by a lead byte, zero for a byte that cannot lead.
   function automatic logic [2:0] lead_length(input logic [7:0] c);
      logic [2:0] len;
      len = 3'd0;
      if ((c & 8'h80) == 8'h00) begin
         len = 3'd1;
      end else if ((c & 8'hE0) == 8'hC0) begin
         len = 3'd2;
      end else if ((c & 8'hF0) == 8'hE0) begin
         len = 3'd3;
      end else if ((c & 8'hF8) == 8'hF0) begin
         len = 3'd4;
      end
      return len;
   endfunction

   function automatic logic [20:0] assemble(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3,
                                            input logic [2:0] len);
      logic [20:0] cp;
      case (len)
         3'd1: begin
            cp = {13'd0, b0};
         end
         3'd2: begin
            cp = {10'd0, b0[4:0], b1[5:0]};
         end
         3'd3: begin
            cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
         end
         default: begin
            cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
         end
      endcase
      return cp;
   endfunction

   // Byte at a position of the four-byte window, zero past its end.
   function automatic logic [7:0] pick(input logic [31:0] seq_w, input logic [2:0] idx);
      logic [7:0] b;
      if (idx > 3'd3) begin
         b = 8'h00;
      end else begin
         b = seq_w[{idx[1:0], 3'b000} +: 8];
      end
      return b;
   endfunction

endpackage

// File: hdl/utf8_stream_decoder_unit.sv
// The first result of a byte is offered in the cycle after its input transfer.
// Throughput: one byte per cycle while each byte gives at most one result and the output
// accepts; a final byte that gives two or three results stalls the input while the
// three-entry result queue drains, one transfer per cycle while the output accepts.
// Reset (synchronous, active high) empties the result queue and drops held bytes.
module utf8_stream_decoder_unit
   import utf8sd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic        rsp_tuser,   // run_end
   output logic        rsp_tlast    // string_end
);

   logic [7:0]    held_ff [HELD_DEPTH];
   logic [7:0]    held_in [HELD_DEPTH];
   logic [1:0]    held_count_ff, held_count_in;
   rsp_entry_type entry_ff [MAX_RESULTS];
   rsp_entry_type entry_in [MAX_RESULTS];
   rsp_entry_type res      [MAX_RESULTS];
   logic [1:0]    count_ff, count_in;
   logic [1:0]    res_count;
   logic          accept, pop;
   logic [31:0]   seq_w;
   logic [2:0]    nb;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tdata  = {3'd0, entry_ff[0].code_point};
   assign rsp_tuser  = entry_ff[0].run_end;
   assign rsp_tlast  = entry_ff[0].string_end;

   // Window of held bytes followed by the incoming byte.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < held_count_ff) begin
            seq_w[i*8 +: 8] = held_ff[i];
         end else if (2'(i) == held_count_ff) begin
            seq_w[i*8 +: 8] = req_tdata;
         end else begin
            seq_w[i*8 +: 8] = 8'h00;
         end
      end
      seq_w[31:24] = (held_count_ff == 2'd3) ? req_tdata : 8'h00;
      nb = {1'b0, held_count_ff} + 3'd1;
   end

   always_comb begin
      logic [2:0]  pos;
      logic [2:0]  len;
      logic [20:0] cp;
      logic [1:0]  k;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '0;
      end
      for (int i = 0; i < HELD_DEPTH; i++) begin
         held_in[i] = held_ff[i];
      end
      held_count_in = held_count_ff;
      pos = 3'd0;
      k   = 2'd0;
      len = lead_length(seq_w[7:0]);
      cp  = SUBST_CHAR;
      if (req_tlast) begin
         // End of string: rescan the window, substituting for any byte that cannot lead or any lead left short.
         for (int j = 0; j < 4; j++) begin
            if (pos < nb) begin
               len = lead_length(pick(seq_w, pos));
               if ((len != 3'd0) && ((pos + len) <= nb)) begin
                  cp  = assemble(pick(seq_w, pos), pick(seq_w, pos + 3'd1),
                                 pick(seq_w, pos + 3'd2), pick(seq_w, pos + 3'd3), len);
                  pos = pos + len;
               end else begin
                  cp  = SUBST_CHAR;
                  pos = pos + 3'd1;
               end
               if (k < 2'd3) begin
                  res[k].code_point = cp;
                  k = k + 2'd1;
               end
            end
         end
         res[k - 2'd1].run_end    = 1'b1;
         res[k - 2'd1].string_end = 1'b1;
         held_count_in = 2'd0;
      end else if (len == 3'd0) begin
         res[0].code_point = SUBST_CHAR;
         res[0].run_end    = 1'b1;
         k = 2'd1;
         held_count_in = 2'd0;
      end else if (nb >= len) begin
         res[0].code_point = assemble(seq_w[7:0], seq_w[15:8], seq_w[23:16],
                                      seq_w[31:24], len);
         res[0].run_end    = 1'b1;
         k = 2'd1;
         held_count_in = 2'd0;
      end else begin
         // Sequence still short: hold the byte.
         for (int i = 0; i < HELD_DEPTH; i++) begin
            held_in[i] = seq_w[i*8 +: 8];
         end
         held_count_in = nb[1:0];
      end
      res_count = k;
   end

   // Result queue: load on an input transfer, otherwise advance on each output transfer.
   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         entry_in[i] = entry_ff[i];
      end
      count_in = count_ff;
      if (accept) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            entry_in[i] = res[i];
         end
         count_in = res_count;
      end else if (pop) begin
         entry_in[0] = entry_ff[1];
         entry_in[1] = entry_ff[2];
         count_in    = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= 2'd0;
         held_count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            held_count_ff <= held_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         entry_ff[i] <= entry_in[i];
      end
      if (accept) begin
         for (int i = 0; i < HELD_DEPTH; i++) begin
            held_ff[i] <= held_in[i];
         end
      end
   end

endmodule

// File: test/testbench.sv
// Self-checking testbench for the UTF-8 stream decoder unit: directed rows, then random strings.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import utf8sd_pkg::*;

   localparam int DIRECTED_ROWS  = 24;
   localparam int RANDOM_ITEMS   = 500;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic [7:0]  in_byte;
      logic        is_last;
      bit          typed;     // cp below is the known single result of this byte
      logic [20:0] cp;
   } byte_row_type;

   typedef logic [7:0] byte_window_type [7];

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   utf8_stream_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   byte_row_type byte_rows [DIRECTED_ROWS] = '{
      '{8'h00, 1'b0, 1'b1, 21'h000000},
      '{8'h7F, 1'b0, 1'b1, 21'h00007F},
      '{8'h80, 1'b0, 1'b1, SUBST_CHAR},   // stray continuation as lead
      '{8'hFF, 1'b0, 1'b1, SUBST_CHAR},
      '{8'hC2, 1'b0, 1'b0, 21'd0},
      '{8'hA9, 1'b0, 1'b0, 21'd0},
      '{8'hE2, 1'b0, 1'b0, 21'd0},
      '{8'h82, 1'b0, 1'b0, 21'd0},
      '{8'hAC, 1'b0, 1'b0, 21'd0},
      '{8'hF7, 1'b0, 1'b0, 21'd0},        // largest four-byte value
      '{8'hBF, 1'b0, 1'b0, 21'd0},
      '{8'hBF, 1'b0, 1'b0, 21'd0},
      '{8'hBF, 1'b1, 1'b0, 21'd0},
      '{8'hF0, 1'b0, 1'b0, 21'd0},        // string ends inside a four-byte sequence
      '{8'h9F, 1'b0, 1'b0, 21'd0},
      '{8'h41, 1'b1, 1'b0, 21'd0},
      '{8'hE2, 1'b0, 1'b0, 21'd0},        // truncated lead, then a truncated two-byte lead
      '{8'hC3, 1'b1, 1'b0, 21'd0},
      '{8'hF0, 1'b0, 1'b0, 21'd0},        // truncated lead hiding a complete sequence
      '{8'hC2, 1'b0, 1'b0, 21'd0},
      '{8'hA9, 1'b1, 1'b0, 21'd0},
      '{8'h41, 1'b1, 1'b1, 21'h000041},
      '{8'hC0, 1'b0, 1'b0, 21'd0},        // overlong form passes through
      '{8'h80, 1'b0, 1'b0, 21'd0}
   };

   byte_row_type  byte_q[$];
   rsp_entry_type due_points[$];
   rsp_entry_type staged_points[$];
   logic [7:0]    held_seq [3];
   int            held_n;
   int            accept_idx;
   int            idle_mode;
   int            fault_count;
   int            results_seen;
   int            strings_seen;
   int            multi_endings;
   int            stuck_cycles;

   function automatic int seq_len(input logic [7:0] c);
      if (!c[7]) return 1;
      if (c[7:5] == 3'b110) return 2;
      if (c[7:4] == 4'b1110) return 3;
      if (c[7:3] == 5'b11110) return 4;
      return 0;
   endfunction

   // Lead payload first, then six bits from each continuation byte.
   function automatic logic [20:0] join_seq(input byte_window_type w, input int at,
                                            input int len);
      logic [20:0] cp;
      cp = (len == 1) ? 21'(w[at]) : 21'(w[at] & (8'h7F >> len));
      for (int k = 1; k < len; k++) begin
         cp = (cp << 6) | 21'(w[at + k][5:0]);
      end
      return cp;
   endfunction

   // Advance the decoder state by one byte and stage the code points it gives.
   task automatic decode_byte(input logic [7:0] b, input logic fin);
      byte_window_type w;
      int n;
      int i;
      int len;
      rsp_entry_type r;
      for (i = 0; i < 7; i++) begin
         w[i] = (i < 3) ? held_seq[i] : 8'h00;
      end
      n = held_n;
      w[n] = b;
      n++;
      r.run_end = 1'b0;
      r.string_end = 1'b0;
      if (fin) begin
         i = 0;
         while (i < n) begin
            len = seq_len(w[i]);
            if (len > 0 && i + len <= n) begin
               r.code_point = join_seq(w, i, len);
               i += len;
            end else begin
               r.code_point = SUBST_CHAR;
               i++;
            end
            staged_points.insert(staged_points.size(), r);
         end
         held_n = 0;
         staged_points[$].run_end = 1'b1;
         staged_points[$].string_end = 1'b1;
      end else begin
         len = seq_len(w[0]);
         if (len == 0 || n >= len) begin
            r.code_point = (len == 0) ? SUBST_CHAR : join_seq(w, 0, len);
            r.run_end = 1'b1;
            staged_points.insert(staged_points.size(), r);
            held_n = 0;
         end else begin
            // hold the unfinished sequence
            for (i = 0; i < 3; i++) begin
               held_seq[i] = w[i];
            end
            held_n = n;
         end
      end
   endtask

   // Queue the first upto bytes of a len-byte sequence with random payload.
   task automatic add_sequence(input int len, input int upto, input bit end_here);
      logic [7:0] b;
      byte_row_type row;
      for (int k = 0; k < upto; k++) begin
         if (k == 0) begin
            case (len)
               1: b = {1'b0, 7'($urandom)};
               2: b = {3'b110, 5'($urandom)};
               3: b = {4'b1110, 4'($urandom)};
               default: b = {5'b11110, 3'($urandom)};
            endcase
         end else begin
            // continuation bytes are not checked, so spoil a few
            b = ($urandom_range(9) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)};
         end
         row = '{b, end_here && (k == upto - 1), 1'b0, 21'd0};
         byte_q.insert(byte_q.size(), row);
      end
   endtask

   always @(posedge clock) begin
      case (idle_mode)
         0: rsp_tready <= ($urandom_range(99) >= 88);
         1: rsp_tready <= ($urandom_range(99) >= 38);
         default: rsp_tready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin : watch_transfers
      rsp_entry_type got;
      rsp_entry_type want;
      byte_row_type  row;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.code_point = rsp_tdata[20:0];
            got.run_end = rsp_tuser;
            got.string_end = rsp_tlast;
            results_seen++;
            if (got.string_end) strings_seen++;
            if (due_points.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("unexpected code point %h run_end %b string_end %b",
                           got.code_point, got.run_end, got.string_end);
               end
            end else begin
               want = due_points.pop_front();
               if (got != want) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $display({"result %0d: expected cp %h run_end %b string_end %b, ",
                               "got cp %h run_end %b string_end %b"},
                              results_seen, want.code_point, want.run_end, want.string_end,
                              got.code_point, got.run_end, got.string_end);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            row = byte_q[accept_idx];
            accept_idx++;
            staged_points.delete();
            decode_byte(row.in_byte, row.is_last);
            if (staged_points.size() > 1) multi_endings++;
            if (row.typed) begin
               want = '{row.cp, 1'b1, row.is_last};
               due_points.insert(due_points.size(), want);
            end else begin
               foreach (staged_points[k]) due_points.insert(due_points.size(), staged_points[k]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("no transfer for %0d cycles, %0d code points outstanding",
                  stuck_cycles, due_points.size());
         $display("Verification failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : drive_bytes
      int pick;
      int count;
      int len;
      int mode;
      int send_idle;
      byte_row_type row;
      held_n = 0;
      accept_idx = 0;
      idle_mode = 0;
      fault_count = 0;
      results_seen = 0;
      strings_seen = 0;
      multi_endings = 0;
      stuck_cycles = 0;
      foreach (byte_rows[k]) byte_q.insert(byte_q.size(), byte_rows[k]);
      // mostly well-formed strings, some cut short, some noise
      while (byte_q.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            count = $urandom_range(1, 6);
            for (int c = 0; c < count; c++) begin
               len = $urandom_range(1, 4);
               add_sequence(len, len, c == count - 1);
            end
         end else if (pick < 88) begin
            count = $urandom_range(0, 3);
            for (int c = 0; c < count; c++) begin
               len = $urandom_range(1, 4);
               add_sequence(len, len, 1'b0);
            end
            len = $urandom_range(2, 4);
            add_sequence(len, $urandom_range(1, len - 1), 1'b1);
         end else begin
            count = $urandom_range(1, 5);
            for (int c = 0; c < count; c++) begin
               row = '{8'($urandom), c == count - 1, 1'b0, 21'd0};
               byte_q.insert(byte_q.size(), row);
            end
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < byte_q.size(); i++) begin
         mode = (i * 3) / byte_q.size();
         send_idle = (mode == 0) ? 38 : (mode == 1) ? 88 : 0;
         idle_mode <= mode;
         if (i == DIRECTED_ROWS) begin
            // hold off until the directed results have all drained
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (due_points.size() != 0) @(posedge clock);
         end
         while ($urandom_range(99) < send_idle) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= byte_q[i].in_byte;
         req_tlast <= byte_q[i].is_last;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (due_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Fed %0d bytes; checked %0d code points across %0d strings.",
               byte_q.size(), results_seen, strings_seen);
      $display("%0d final bytes gave several code points; %0d faults seen.",
               multi_endings, fault_count);
      if (fault_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/utf8sd_pkg.sv
hdl/utf8_stream_decoder_unit.sv
test/testbench.sv
